/* rtl/core/aes_pkg.sv */
// package: payload types, s-box tables and round helpers for the aes-128 cipher
package aes_pkg;

	localparam int NumRounds = 10;

	localparam logic [1:0] CfgKeyHigh = 2'd0;
	localparam logic [1:0] CfgKeyLow  = 2'd1;

	typedef enum logic {
		REQ_ENCRYPT = 1'b0,
		REQ_DECRYPT = 1'b1
	} req_type_t;

	typedef struct packed {
		logic        req_type;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	typedef logic [127:0] state_t;

	// sbox, forward direction
	function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] sbox_rev(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[a];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] t [10];
		t = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
		return (r < 4'd10) ? t[r] : 8'h00;
	endfunction

	// byte k of the state; byte 0 in the top bits
	function automatic logic [7:0] get_b(input state_t s, input int k);
		return s[127-8*k -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic state_t sub_shift_fwd(input state_t s);
		state_t o;
		logic [3:0] m [16];
		m = '{4'd0,4'd5,4'd10,4'd15,4'd4,4'd9,4'd14,4'd3,
			4'd8,4'd13,4'd2,4'd7,4'd12,4'd1,4'd6,4'd11};
		for (int k = 0; k < 16; k++) o[127-8*k -: 8] = sbox_fwd(get_b(s, int'(m[k])));
		return o;
	endfunction

	function automatic state_t sub_shift_inv(input state_t s);
		state_t o;
		logic [3:0] m [16];
		m = '{4'd0,4'd13,4'd10,4'd7,4'd4,4'd1,4'd14,4'd11,
			4'd8,4'd5,4'd2,4'd15,4'd12,4'd9,4'd6,4'd3};
		for (int k = 0; k < 16; k++) o[127-8*k -: 8] = sbox_rev(get_b(s, int'(m[k])));
		return o;
	endfunction

	function automatic state_t mix_fwd(input state_t s);
		state_t o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
			a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
			o[127-32*c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			o[119-32*c -: 8]  = xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ a0;
			o[111-32*c -: 8]  = xt(a2) ^ xt(a3) ^ a3 ^ a0 ^ a1;
			o[103-32*c -: 8]  = xt(a3) ^ xt(a0) ^ a0 ^ a1 ^ a2;
		end
		return o;
	endfunction

	// inverse mix as a pre-step (05 04 product) then forward mix
	function automatic state_t mix_inv(input state_t s);
		state_t p;
		logic [7:0] a0, a1, a2, a3, u, v;
		for (int c = 0; c < 4; c++) begin
			a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
			a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
			u = xt(xt(a0 ^ a2));
			v = xt(xt(a1 ^ a3));
			p[127-32*c -: 8] = a0 ^ u;
			p[119-32*c -: 8] = a1 ^ v;
			p[111-32*c -: 8] = a2 ^ u;
			p[103-32*c -: 8] = a3 ^ v;
		end
		return mix_fwd(p);
	endfunction

	// next round key from the previous one
	function automatic state_t key_next(input state_t k, input logic [3:0] r);
		state_t o;
		logic [31:0] t;
		t = {sbox_fwd(k[23:16]) ^ rcon(r), sbox_fwd(k[15:8]), sbox_fwd(k[7:0]),
			sbox_fwd(k[31:24])};
		o[127:96] = k[127:96] ^ t;
		o[95:64]  = k[95:64] ^ o[127:96];
		o[63:32]  = k[63:32] ^ o[95:64];
		o[31:0]   = k[31:0] ^ o[63:32];
		return o;
	endfunction

endpackage

/* rtl/core/aes_key_sched.sv */
// key schedule: eleven round keys, one expansion step per register stage
module aes_key_sched
	import aes_pkg::*;
(
	input  logic   clk,
	input  state_t key,
	output state_t rk [NumRounds+1]
);
	state_t rk_q [NumRounds+1];

	// round key r is registered from round key r-1 (register 0 takes the key)
	always_ff @(posedge clk) begin
		rk_q[0] <= key;
		for (int r = 1; r <= NumRounds; r++) rk_q[r] <= key_next(rk_q[r-1], 4'(r-1));
	end

	assign rk = rk_q;
endmodule

/* rtl/core/aes_round.sv */
// one pipeline stage: a forward or an inverse round
module aes_round
	import aes_pkg::*;
#(
	parameter bit LastRound = 1'b0
) (
	input  logic   dec,
	input  state_t din,
	input  state_t key_enc,
	input  state_t key_dec,
	output state_t dout
);
	state_t e, d;
	always_comb begin
		e = sub_shift_fwd(din);
		if (!LastRound) e = mix_fwd(e);
		e = e ^ key_enc;
		d = sub_shift_inv(din) ^ key_dec;
		if (!LastRound) d = mix_inv(d);
		dout = dec ? d : e;
	end
endmodule

/* rtl/core/aes128_block_cipher.sv */
// top level: pipelined aes-128 encrypt and decrypt engine
// usage:
//   cfg_valid/cfg_ready write key_high (index 0) and key_low (index 1); other
//   indexes are dropped. cfg_ready is always high. write the key only while idle.
//   after a write or a reset, in_stall stays high until the round keys have
//   settled.
//   in_valid/in_stall take a request carrying req_type and the 128-bit block.
//   out_valid/out_stall deliver the result block.
// pipeline: one register after the initial key add, then one per round; the
//   last round register drives out_data.
// throughput: one request per cycle while in_stall is low; each round stage
//   holds one full round of logic between registers.
// stall: a stall on the output freezes the whole pipeline; in_stall follows
//   out_stall while the output register is full, so nothing is lost or
//   repeated. bubbles inside the pipe are held in place during a stall.
// reset: arst_n clears the key to zero and every valid bit.
module aes128_block_cipher
	import aes_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	logic [63:0] key_high_q, key_low_q;
	logic [3:0]  key_wait_q;
	logic        key_busy;
	state_t rk [NumRounds+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgKeyHigh: key_high_q <= cfg_data;
				CfgKeyLow:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold off requests until the round key pipe has caught up with the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_wait_q <= 4'(NumRounds+1);
		end else if (cfg_valid && cfg_ready) begin
			key_wait_q <= 4'(NumRounds+1);
		end else if (key_wait_q != 4'd0) begin
			key_wait_q <= key_wait_q - 4'd1;
		end
	end

	assign key_busy = (key_wait_q != 4'd0);

	aes_key_sched u_ks (.clk(clk), .key({key_high_q, key_low_q}), .rk(rk));

	// stage r holds the state after round r (index 0 after the initial key add)
	logic   vld_s [NumRounds+1];
	logic   dec_s [NumRounds+1];
	state_t st_s  [NumRounds+1];
	state_t nxt   [NumRounds+1];

	// the whole pipe advances unless the output stage is full and stalled
	logic adv;
	assign adv = !(vld_s[NumRounds] && out_stall);
	assign in_stall = !adv || key_busy;

	assign nxt[0] = {in_data.block_high, in_data.block_low}
		^ (in_data.req_type ? rk[NumRounds] : rk[0]);

	for (genvar r = 1; r <= NumRounds; r++) begin : g_rnd
		aes_round #(.LastRound(r == NumRounds)) u_rnd (
			.dec(dec_s[r-1]), .din(st_s[r-1]),
			.key_enc(rk[r]), .key_dec(rk[NumRounds-r]), .dout(nxt[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r <= NumRounds; r++) vld_s[r] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid && !key_busy;
			for (int r = 1; r <= NumRounds; r++) vld_s[r] <= vld_s[r-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]  <= nxt[0];
			dec_s[0] <= in_data.req_type;
			for (int r = 1; r <= NumRounds; r++) begin
				st_s[r]  <= nxt[r];
				dec_s[r] <= dec_s[r-1];
			end
		end
	end

	assign out_valid = vld_s[NumRounds];
	assign out_data  = '{result_high: st_s[NumRounds][127:64],
		result_low: st_s[NumRounds][63:0]};
endmodule

/* tb/aes128_block_cipher_test.sv */
// testbench for the aes-128 pipelined cipher: random and directed blocks checked against a predictor
`timescale 1ns / 100ps

module aes128_block_cipher_test;
	import aes_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	aes128_block_cipher dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	localparam int WatchdogLimit = 2000;
	localparam int PipeDepth = 11;

	// cipher key as the predictor sees it
	logic [63:0] key_hi_q, key_lo_q;

	in_item_t pending_requests[$];
	out_item_t expected_blocks[$];
	int errors;
	int idle_count;
	bit sender_hold;

	// clock, 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// predictor: built from gf(2^8) arithmetic, not table lookups
	// ---------------------------------------------------------------
	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[0]) p ^= a;
			a = gf_dbl(a);
			b = b >> 1;
		end
		return p;
	endfunction

	// inverse as a^254, zero maps to zero
	function automatic logic [7:0] gf_recip(input logic [7:0] a);
		logic [7:0] r, base;
		int e;
		r = 8'h01;
		base = a;
		e = 254;
		while (e != 0) begin
			if (e & 1) r = gf_mul(r, base);
			base = gf_mul(base, base);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] subst_byte(input logic [7:0] a);
		logic [7:0] b;
		b = gf_recip(a);
		return b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] unsubst_byte(input logic [7:0] s);
		return gf_recip(rot8(s, 1) ^ rot8(s, 3) ^ rot8(s, 6) ^ 8'h05);
	endfunction

	// full cipher on one request; bytes held as an array, byte 0 first
	function automatic out_item_t cipher_block(input in_item_t req, input logic [63:0] kh,
		input logic [63:0] kl);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] w [4];
		logic [7:0] f, rc;
		logic [7:0] a [4];
		int fwd_map [16];
		int inv_map [16];
		out_item_t res;
		fwd_map = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
		inv_map = '{0, 13, 10, 7, 4, 1, 14, 11, 8, 5, 2, 15, 12, 9, 6, 3};
		rc = 8'h01;
		for (int k = 0; k < 8; k++) begin
			rk[k] = kh[63-8*k -: 8];
			rk[8+k] = kl[63-8*k -: 8];
			st[k] = req.block_high[63-8*k -: 8];
			st[8+k] = req.block_low[63-8*k -: 8];
		end
		// key expansion, one word at a time
		for (int pos = 16; pos < 176; pos += 4) begin
			for (int k = 0; k < 4; k++) w[k] = rk[pos-4+k];
			if ((pos % 16) == 0) begin
				f = w[0];
				w[0] = subst_byte(w[1]) ^ rc;
				w[1] = subst_byte(w[2]);
				w[2] = subst_byte(w[3]);
				w[3] = subst_byte(f);
				rc = gf_dbl(rc);
			end
			for (int k = 0; k < 4; k++) rk[pos+k] = w[k] ^ rk[pos-16+k];
		end
		if (req_type_t'(req.req_type) == REQ_ENCRYPT) begin
			for (int k = 0; k < 16; k++) st[k] ^= rk[k];
			for (int r = 1; r <= NumRounds; r++) begin
				for (int k = 0; k < 16; k++) tmp[k] = subst_byte(st[fwd_map[k]]);
				st = tmp;
				if (r != NumRounds)
					for (int c = 0; c < 4; c++) begin
						for (int j = 0; j < 4; j++) a[j] = st[4*c+j];
						for (int j = 0; j < 4; j++)
							st[4*c+j] = gf_mul(a[j], 8'h02) ^ gf_mul(a[(j+1)%4], 8'h03)
								^ a[(j+2)%4] ^ a[(j+3)%4];
					end
				for (int k = 0; k < 16; k++) st[k] ^= rk[16*r+k];
			end
		end else begin
			for (int k = 0; k < 16; k++) st[k] ^= rk[16*NumRounds+k];
			for (int r = NumRounds - 1; r >= 0; r--) begin
				for (int k = 0; k < 16; k++) tmp[k] = unsubst_byte(st[inv_map[k]]);
				st = tmp;
				for (int k = 0; k < 16; k++) st[k] ^= rk[16*r+k];
				if (r != 0)
					for (int c = 0; c < 4; c++) begin
						for (int j = 0; j < 4; j++) a[j] = st[4*c+j];
						for (int j = 0; j < 4; j++)
							st[4*c+j] = gf_mul(a[j], 8'h0e) ^ gf_mul(a[(j+1)%4], 8'h0b)
								^ gf_mul(a[(j+2)%4], 8'h0d) ^ gf_mul(a[(j+3)%4], 8'h09);
					end
			end
		end
		for (int k = 0; k < 8; k++) begin
			res.result_high[63-8*k -: 8] = st[k];
			res.result_low[63-8*k -: 8] = st[8+k];
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// request driver: changes inputs on the falling edge
	// ---------------------------------------------------------------
	int send_gap;
	bit in_fire;

	always @(posedge clk) in_fire <= in_valid && !in_stall;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else begin
			// request accepted at the last rising edge, or the lane is free
			if (in_fire || !in_valid) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_requests.size() > 0 && !sender_hold) begin
					in_valid <= 1'b1;
					in_data <= pending_requests.pop_front();
					send_gap <= $urandom_range(0, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// predictions are made on acceptance, with the key in force then
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_blocks.push_back(cipher_block(in_data, key_hi_q, key_lo_q));
	end

	// ---------------------------------------------------------------
	// result stall generator: a random count per result, sometimes none
	// ---------------------------------------------------------------
	int stall_left;
	bit stall_quiet;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			// new draw after each delivered result
			if (out_valid && !out_stall)
				stall_left <= stall_quiet ? 0 : $urandom_range(0, 4);
		end
	end

	// ---------------------------------------------------------------
	// result monitor: sampled at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t exp_blk;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				$error("result with no request outstanding: %h", out_data);
				errors++;
			end else begin
				exp_blk = expected_blocks.pop_front();
				if (out_data.result_high !== exp_blk.result_high) begin
					$error("result_high expected %h actual %h", exp_blk.result_high,
						out_data.result_high);
					errors++;
				end
				if (out_data.result_low !== exp_blk.result_low) begin
					$error("result_low expected %h actual %h", exp_blk.result_low,
						out_data.result_low);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no request and no result moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= WatchdogLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CfgKeyHigh) key_hi_q = val;
		else if (idx == CfgKeyLow) key_lo_q = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_block(input req_type_t op, input logic [63:0] hi, input logic [63:0] lo);
		in_item_t r;
		r.req_type = op;
		r.block_high = hi;
		r.block_low = lo;
		pending_requests.push_back(r);
	endtask

	// wait for the pipe to drain, then the round keys' settling time
	task automatic drain_pipe();
		wait (pending_requests.size() == 0);
		while (in_valid || expected_blocks.size() > 0) @(posedge clk);
		repeat (PipeDepth) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		logic [63:0] hi, lo;
		sender_hold = 0;
		stall_quiet = 0;
		key_hi_q = '0;
		key_lo_q = '0;
		cfg_valid = 1'b0;
		cfg_index = CfgKeyHigh;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// never-written key is all zero
		queue_block(REQ_ENCRYPT, '0, '0);
		queue_block(REQ_DECRYPT, '0, '0);
		queue_block(REQ_ENCRYPT, '1, '1);
		drain_pipe();

		// fips-197 example key, plus dropped writes to the two unused indexes
		write_key(CfgKeyHigh, 64'h0001020304050607);
		write_key(CfgKeyLow, 64'h08090a0b0c0d0e0f);
		write_key(2'd2, 64'hdeadbeefdeadbeef);
		write_key(2'd3, 64'h0123456789abcdef);
		queue_block(REQ_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		queue_block(REQ_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		queue_block(REQ_ENCRYPT, '0, '1);
		queue_block(REQ_DECRYPT, '1, '0);
		queue_block(REQ_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
		drain_pipe();

		// all-ones key
		write_key(CfgKeyHigh, '1);
		write_key(CfgKeyLow, '1);
		queue_block(REQ_ENCRYPT, '0, '0);
		queue_block(REQ_DECRYPT, '0, '0);
		queue_block(REQ_ENCRYPT, '1, '1);
		queue_block(REQ_DECRYPT, '1, '1);
		queue_block(REQ_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		queue_block(REQ_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain_pipe();

		// random phases, new key each; one phase with no output stall
		for (int ph = 0; ph < 8; ph++) begin
			write_key(CfgKeyHigh, rand64());
			write_key(CfgKeyLow, rand64());
			stall_quiet = (ph == 3);
			for (int n = 0; n < 94; n++) begin
				hi = rand64();
				lo = rand64();
				queue_block(req_type_t'($urandom_range(0, 1)), hi, lo);
				// pair: decrypt then encrypt of the same block
				if ($urandom_range(0, 7) == 0) begin
					queue_block(REQ_DECRYPT, hi, lo);
					queue_block(REQ_ENCRYPT, hi, lo);
				end
			end
			// sender holds off mid-phase until everything has come back
			if (ph == 5) begin
				wait (pending_requests.size() < 50);
				sender_hold = 1;
				while (in_valid || expected_blocks.size() > 0) @(posedge clk);
				sender_hold = 0;
			end
			drain_pipe();
		end

		// end of run
		repeat (PipeDepth + 5) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
